/* rtl/sqd_pkg.sv */
`default_nettype none

package sqd_pkg;

    localparam int unsigned TAB_DEPTH   = 128;
    localparam int unsigned CODE_SPAN_SQ = 65025;
    localparam int unsigned FRAC_SHIFT  = 30;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned ROOT_STAGES = 8;

    localparam logic [7:0]         TAG_BASE = 8'd252;
    localparam logic signed [15:0] Q_ONE    = 16'sd16384;
    localparam logic [16:0]        SQ_DEN   = 17'd130050;

    // Rounded-up reciprocal of SQ_DEN; the quotient estimate is exact or one too high.
    localparam logic [31:0] RECIP = 32'(((64'd1 << (FRAC_SHIFT + RECIP_SHIFT))
                                         + 64'(SQ_DEN) - 64'd1) / 64'(SQ_DEN));

    typedef logic [13:0] t_qmag;
    typedef logic [15:0] t_qsq;
    typedef logic [TAB_DEPTH-1:0][13:0] t_qmag_tab;
    typedef logic [TAB_DEPTH-1:0][15:0] t_qsq_tab;

    typedef enum logic [1:0] {
        SLOT_W,
        SLOT_X,
        SLOT_Y,
        SLOT_Z
    } t_slot;

    typedef struct packed {
        logic signed [15:0] qa;
        logic signed [15:0] qb;
        logic signed [15:0] qc;
        t_slot              slot;
        logic               ident;
        logic               last;
    } t_side;

    function automatic t_qmag_tab build_qmag();
        t_qmag_tab       tab;
        longint unsigned mag;
        longint unsigned num4;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        int              k;
        tab = '0;
        for (k = 0; k < TAB_DEPTH; k++) begin
            mag  = 64'(2 * k + 1);
            num4 = (mag * mag) << 29;
            lo   = 0;
            hi   = 32767;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                t   = 2 * mid - 1;
                if (t * t * CODE_SPAN_SQ <= num4) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            tab[k] = lo[13:0];
        end
        return tab;
    endfunction

    function automatic t_qsq_tab build_qsq();
        t_qsq_tab        tab;
        longint unsigned mag;
        int              k;
        tab = '0;
        for (k = 0; k < TAB_DEPTH; k++) begin
            mag    = 64'(2 * k + 1);
            tab[k] = 16'(mag * mag);
        end
        return tab;
    endfunction

    localparam t_qmag_tab QMAG_TAB = build_qmag();
    localparam t_qsq_tab  QSQ_TAB  = build_qsq();

    // Codes pair up around the midpoint, so one half-size table serves both signs.
    function automatic logic [6:0] tab_index(input logic [7:0] code);
        return code[7] ? code[6:0] : ~code[6:0];
    endfunction

    function automatic logic signed [15:0] code_to_q(input logic [7:0] code);
        logic signed [15:0] mag;
        mag = signed'({2'b00, QMAG_TAB[tab_index(code)]});
        return code[7] ? mag : -mag;
    endfunction

endpackage

`default_nettype wire

/* rtl/sqd_root_pipe.sv */
`default_nettype none

module sqd_root_pipe import sqd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_rad,
    output logic      [15:0] o_root
);

    typedef struct packed {
        logic [19:0] rem;
        logic [15:0] root;
        logic [31:0] rad;
    } t_root_st;

    function automatic t_root_st root_step(input t_root_st s);
        t_root_st    o;
        logic [19:0] trial;
        o.rem = {s.rem[17:0], s.rad[31:30]};
        o.rad = {s.rad[29:0], 2'b00};
        trial = {2'b00, s.root, 2'b01};
        if (o.rem >= trial) begin
            o.rem  = o.rem - trial;
            o.root = {s.root[14:0], 1'b1};
        end else begin
            o.root = {s.root[14:0], 1'b0};
        end
        return o;
    endfunction

    t_root_st r_st [ROOT_STAGES];
    t_root_st n_st [ROOT_STAGES];

    always_comb begin
        n_st[0] = root_step(root_step('{rem: '0, root: '0, rad: i_rad}));
        for (int k = 1; k < ROOT_STAGES; k++) begin
            n_st[k] = root_step(root_step(r_st[k-1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[ROOT_STAGES-1].root;

endmodule

`default_nettype wire

/* rtl/smallest_three_quat_decode.sv */
// Smallest-three quaternion decoder.
// Input channel (i_valid/o_ready): three 8-bit component codes, a slot tag and a
// last flag make one word. Output channel (o_valid/i_ready): one word per input
// word, holding w, x, y and z as signed Q1.14 and the copied last flag.
// The tag selects the slot of the reconstructed component; a tag below 252 gives
// the identity quaternion.
// The pipeline has one stage for the code tables and the sum of squares, two for
// the constant division, eight for the two-bits-per-stage square root and one for
// the slot select. Throughput is one word per cycle when the receiver keeps up.
// When the receiver stalls, the whole pipeline holds; a one-word skid register on
// the input takes the word offered in that cycle, so o_ready does not depend on
// i_ready combinationally. Words keep their order and none is lost or repeated.
// Reset clears all valid bits, the skid valid bit too; o_ready is high after reset.
`default_nettype none

module smallest_three_quat_decode import sqd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [7:0]  i_code_a,
    input  wire logic        [7:0]  i_code_b,
    input  wire logic        [7:0]  i_code_c,
    input  wire logic        [7:0]  i_slot_tag,
    input  wire logic               i_last_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed      [15:0] o_quat_w,
    output logic signed      [15:0] o_quat_x,
    output logic signed      [15:0] o_quat_y,
    output logic signed      [15:0] o_quat_z,
    output logic                    o_last_out
);

    logic        en;
    logic        src_v;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  src_c;
    logic [7:0]  src_tag;
    logic        src_last;

    logic        r_skid_v;
    logic [7:0]  r_skid_a;
    logic [7:0]  r_skid_b;
    logic [7:0]  r_skid_c;
    logic [7:0]  r_skid_tag;
    logic        r_skid_last;

    logic [17:0] s1_sum;
    t_side       n_s1_sb;
    logic [16:0] n_s1_rem;

    logic        r_s1_v;
    t_side       r_s1_sb;
    logic [16:0] r_s1_rem;

    logic [48:0] s2_prod;
    logic        r_s2_v;
    t_side       r_s2_sb;
    logic [16:0] r_s2_rem;
    logic [30:0] r_s2_fest;

    logic [47:0] s3_chk;
    logic [47:0] s3_num;
    logic [30:0] n_s3_f;
    logic        r_s3_v;
    t_side       r_s3_sb;
    logic [30:0] r_s3_f;

    logic [ROOT_STAGES-1:0] r_rt_v;
    t_side                  r_rt_sb [ROOT_STAGES];
    logic [15:0]            root;

    logic signed [15:0] qd;
    logic signed [15:0] n_w;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
    t_side              last_sb;

    logic               r_out_v;
    logic signed [15:0] r_out_w;
    logic signed [15:0] r_out_x;
    logic signed [15:0] r_out_y;
    logic signed [15:0] r_out_z;
    logic               r_out_last;

    assign en      = !r_out_v || i_ready;
    assign o_ready = !r_skid_v;

    assign src_v    = r_skid_v || i_valid;
    assign src_a    = r_skid_v ? r_skid_a    : i_code_a;
    assign src_b    = r_skid_v ? r_skid_b    : i_code_b;
    assign src_c    = r_skid_v ? r_skid_c    : i_code_c;
    assign src_tag  = r_skid_v ? r_skid_tag  : i_slot_tag;
    assign src_last = r_skid_v ? r_skid_last : i_last_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_valid && o_ready) begin
            r_skid_a    <= i_code_a;
            r_skid_b    <= i_code_b;
            r_skid_c    <= i_code_c;
            r_skid_tag  <= i_slot_tag;
            r_skid_last <= i_last_in;
        end
    end

    always_comb begin
        s1_sum = 18'(QSQ_TAB[tab_index(src_a)]) + 18'(QSQ_TAB[tab_index(src_b)])
               + 18'(QSQ_TAB[tab_index(src_c)]);
        n_s1_rem      = (s1_sum < 18'(SQ_DEN)) ? 17'(18'(SQ_DEN) - s1_sum) : '0;
        n_s1_sb.qa    = code_to_q(src_a);
        n_s1_sb.qb    = code_to_q(src_b);
        n_s1_sb.qc    = code_to_q(src_c);
        n_s1_sb.slot  = t_slot'(src_tag[1:0]);
        n_s1_sb.ident = src_tag < TAG_BASE;
        n_s1_sb.last  = src_last;
    end

    // The remaining radicand is scaled by 2^30 and divided by SQ_DEN in two steps:
    // a reciprocal estimate, then a one-step correction.
    assign s2_prod = 49'(r_s1_rem) * 49'(RECIP);
    assign s3_chk  = 48'(r_s2_fest) * 48'(SQ_DEN);
    assign s3_num  = 48'({r_s2_rem, 30'd0});
    assign n_s3_f  = (s3_chk > s3_num) ? r_s2_fest - 31'd1 : r_s2_fest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_rt_v  <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= src_v;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_rt_v  <= {r_rt_v[ROOT_STAGES-2:0], r_s3_v};
            r_out_v <= r_rt_v[ROOT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sb    <= n_s1_sb;
            r_s1_rem   <= n_s1_rem;
            r_s2_sb    <= r_s1_sb;
            r_s2_rem   <= r_s1_rem;
            r_s2_fest  <= s2_prod[RECIP_SHIFT +: 31];
            r_s3_sb    <= r_s2_sb;
            r_s3_f     <= n_s3_f;
            r_rt_sb[0] <= r_s3_sb;
            for (int k = 1; k < ROOT_STAGES; k++) begin
                r_rt_sb[k] <= r_rt_sb[k-1];
            end
            r_out_w    <= n_w;
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_z    <= n_z;
            r_out_last <= last_sb.last;
        end
    end

    sqd_root_pipe u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({1'b0, r_s3_f}),
        .o_root (root)
    );

    // The integer root u of the scaled radicand gives the rounded result as (u+1)/2.
    assign last_sb = r_rt_sb[ROOT_STAGES-1];
    assign qd      = signed'(16'((17'(root) + 17'd1) >> 1));

    always_comb begin
        n_w = last_sb.qa;
        n_x = last_sb.qb;
        n_y = last_sb.qc;
        n_z = qd;
        unique case (last_sb.slot)
            SLOT_W: begin
                n_w = qd;
                n_x = last_sb.qa;
                n_y = last_sb.qb;
                n_z = last_sb.qc;
            end
            SLOT_X: begin
                n_w = last_sb.qa;
                n_x = qd;
                n_y = last_sb.qb;
                n_z = last_sb.qc;
            end
            SLOT_Y: begin
                n_w = last_sb.qa;
                n_x = last_sb.qb;
                n_y = qd;
                n_z = last_sb.qc;
            end
            SLOT_Z: begin
                n_w = last_sb.qa;
                n_x = last_sb.qb;
                n_y = last_sb.qc;
                n_z = qd;
            end
            default: begin
                n_w = Q_ONE;
                n_x = '0;
                n_y = '0;
                n_z = '0;
            end
        endcase
        if (last_sb.ident) begin
            n_w = Q_ONE;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    assign o_valid    = r_out_v;
    assign o_quat_w   = r_out_w;
    assign o_quat_x   = r_out_x;
    assign o_quat_y   = r_out_y;
    assign o_quat_z   = r_out_z;
    assign o_last_out = r_out_last;

endmodule

`default_nettype wire

/* rtl/sqd_checker.sv */
`default_nettype none

module sqd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic signed [15:0] o_quat_w,
    input wire logic signed [15:0] o_quat_x,
    input wire logic signed [15:0] o_quat_y,
    input wire logic signed [15:0] o_quat_z,
    input wire logic               o_last_out
);

    // A stalled output word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x)
            && $stable(o_quat_y) && $stable(o_quat_z) && $stable(o_last_out))
        else $error("output word changed while stalled");

    // The input side closes only when a word arrives while the output is stalled.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid) && $past(o_valid) && !$past(i_ready))
        else $error("input ready dropped without an output stall");

    // Once the output can advance, the skid register drains in the next cycle.
    a_ready_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && (!o_valid || i_ready) |=> o_ready)
        else $error("skid register did not drain");

    // Every component of a valid word lies within the unit range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_w >= -16'sd16384 && o_quat_w <= 16'sd16384
            && o_quat_x >= -16'sd16384 && o_quat_x <= 16'sd16384
            && o_quat_y >= -16'sd16384 && o_quat_y <= 16'sd16384
            && o_quat_z >= -16'sd16384 && o_quat_z <= 16'sd16384)
        else $error("component outside the unit range");

endmodule

bind smallest_three_quat_decode sqd_checker u_sqd_checker (.*);

`default_nettype wire

/* tb/smallest_three_quat_decode_tb.sv */
`default_nettype none

module smallest_three_quat_decode_tb import sqd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } t_quat_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic        [7:0]  i_code_a = '0;
    logic        [7:0]  i_code_b = '0;
    logic        [7:0]  i_code_c = '0;
    logic        [7:0]  i_slot_tag = '0;
    logic               i_last_in = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_quat_w;
    logic signed [15:0] o_quat_x;
    logic signed [15:0] o_quat_y;
    logic signed [15:0] o_quat_z;
    logic               o_last_out;

    t_quat_word pending_quats[$];
    t_quat_word want_quat;
    int         mismatch_count = 0;
    bit         steady = 1'b0;

    smallest_three_quat_decode dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_code_a   (i_code_a),
        .i_code_b   (i_code_b),
        .i_code_c   (i_code_c),
        .i_slot_tag (i_slot_tag),
        .i_last_in  (i_last_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_quat_w   (o_quat_w),
        .o_quat_x   (o_quat_x),
        .o_quat_y   (o_quat_y),
        .o_quat_z   (o_quat_z),
        .o_last_out (o_last_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned nearest_sqrt(input longint unsigned num4,
                                                     input longint unsigned den);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        lo = 0;
        hi = 32767;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 2 * mid - 1;
            if (t * t * den <= num4) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic longint unsigned code_square(input logic [7:0] code);
        int n;
        n = 2 * int'(code) - 255;
        if (n < 0) begin
            n = -n;
        end
        return longint'(n) * longint'(n);
    endfunction

    function automatic logic signed [15:0] code_component(input logic [7:0] code);
        logic signed [15:0] mag;
        mag = 16'(nearest_sqrt(code_square(code) << 29, 64'(CODE_SPAN_SQ)));
        return code[7] ? mag : -mag;
    endfunction

    function automatic t_quat_word decode_quat(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic [7:0] tag,
                                               input logic last);
        t_quat_word         r;
        logic signed [15:0] qa;
        logic signed [15:0] qb;
        logic signed [15:0] qc;
        logic signed [15:0] qd;
        longint unsigned    sum_sq;
        t_slot              slot;
        r.w    = Q_ONE;
        r.x    = '0;
        r.y    = '0;
        r.z    = '0;
        r.last = last;
        if (tag >= TAG_BASE) begin
            qa     = code_component(a);
            qb     = code_component(b);
            qc     = code_component(c);
            sum_sq = code_square(a) + code_square(b) + code_square(c);
            qd     = '0;
            if (sum_sq < 64'(SQ_DEN)) begin
                qd = 16'(nearest_sqrt((64'(SQ_DEN) - sum_sq) << 30, 64'(SQ_DEN)));
            end
            slot = t_slot'(2'(tag - TAG_BASE));
            case (slot)
                SLOT_W: begin
                    r.w = qd; r.x = qa; r.y = qb; r.z = qc;
                end
                SLOT_X: begin
                    r.x = qd; r.w = qa; r.y = qb; r.z = qc;
                end
                SLOT_Y: begin
                    r.y = qd; r.w = qa; r.x = qb; r.z = qc;
                end
                default: begin
                    r.z = qd; r.w = qa; r.x = qb; r.y = qc;
                end
            endcase
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pending_quats = {pending_quats, decode_quat(i_code_a, i_code_b, i_code_c,
                                                            i_slot_tag, i_last_in)};
            end
            if (o_valid && i_ready) begin
                if (pending_quats.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatch_count++;
                end else begin
                    want_quat = pending_quats.pop_front();
                    if (o_quat_w !== want_quat.w) begin
                        $error("quat_w expected %0d got %0d", want_quat.w, o_quat_w);
                        mismatch_count++;
                    end
                    if (o_quat_x !== want_quat.x) begin
                        $error("quat_x expected %0d got %0d", want_quat.x, o_quat_x);
                        mismatch_count++;
                    end
                    if (o_quat_y !== want_quat.y) begin
                        $error("quat_y expected %0d got %0d", want_quat.y, o_quat_y);
                        mismatch_count++;
                    end
                    if (o_quat_z !== want_quat.z) begin
                        $error("quat_z expected %0d got %0d", want_quat.z, o_quat_z);
                        mismatch_count++;
                    end
                    if (o_last_out !== want_quat.last) begin
                        $error("last_out expected %0d got %0d", want_quat.last, o_last_out);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] tag, input logic last);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 9) begin
            gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_code_a   <= a;
        i_code_b   <= b;
        i_code_c   <= c;
        i_slot_tag <= tag;
        i_last_in  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_quats.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] edge_codes[8] = '{8'd0, 8'd1, 8'd126, 8'd127,
                                      8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(3) == 0) begin
            return edge_codes[$urandom_range(7)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_identity_tags();
        send_word(8'd255, 8'd0, 8'd128, 8'd0, 1'b0);
        send_word(8'd0, 8'd255, 8'd127, 8'd251, 1'b1);
        send_word(8'hAA, 8'h55, 8'hF0, 8'h7F, 1'b0);
        send_word(8'h55, 8'hAA, 8'h0F, 8'h80, 1'b1);
    endtask

    task automatic test_slot_tags();
        int k;
        for (k = 0; k < 4; k++) begin
            send_word(8'd0, 8'd128, 8'd255, TAG_BASE + 8'(k), 1'(k));
            send_word(8'd127, 8'd128, 8'd127, TAG_BASE + 8'(k), 1'(~k));
            send_word(8'd200, 8'd40, 8'd90, TAG_BASE + 8'(k), 1'b0);
        end
    endtask

    task automatic test_negative_radicand();
        send_word(8'd0, 8'd0, 8'd0, 8'd252, 1'b1);
        send_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd255, 8'd0, 8'd253, 1'b1);
        send_word(8'd255, 8'd0, 8'd200, 8'd254, 1'b0);
        send_word(8'd255, 8'd255, 8'd128, 8'd252, 1'b1);
    endtask

    task automatic test_random_words();
        int         k;
        logic [7:0] tag;
        for (k = 0; k < 1650; k++) begin
            steady = (k >= 400 && k < 700);
            if (k == 900) begin
                wait_for_drain();
            end
            if ($urandom_range(99) < 85) begin
                tag = TAG_BASE + 8'($urandom_range(3));
            end else begin
                tag = 8'($urandom_range(255));
            end
            send_word(pick_code(), pick_code(), pick_code(), tag, 1'($urandom_range(1)));
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_identity_tags();
        test_slot_tags();
        test_negative_radicand();
        test_random_words();
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
